// ----- hdl/cebv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the coincidence event builder with veto.
// No dependencies; every other file in hdl/ imports this package.
package cebv_pkg;

    localparam logic [4:0]  GROUP_A_FIRST_ID = 5'd1;
    localparam logic [4:0]  GROUP_B_FIRST_ID = 5'd9;
    localparam logic [4:0]  GUARD_ID         = 5'd20;
    localparam logic [15:0] WINDOW_AT_RESET  = 16'd300;

    localparam int ENERGY_OUT_W    = 20;
    localparam int CHAN_IDX_W      = 4;   // enough for two groups of up to 8
    localparam int CMD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] hit_time;
        logic [4:0]  detector_id;
        logic [15:0] hit_energy;
        logic        end_of_event;
    } t_hit;

    typedef struct packed {
        logic [2:0]              channel;
        logic [ENERGY_OUT_W-1:0] energy_sum;
        logic                    vetoed;
        logic                    last;
    } t_result;

    // One classified hit for the back end
    typedef struct packed {
        logic                  flush_pre;
        logic                  flush_post;
        logic                  add_chan;
        logic                  add_guard;
        logic [CHAN_IDX_W-1:0] chan;
        logic [15:0]           energy;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PRE,
        BK_POST
    } t_bk_state;

endpackage

// ----- hdl/cebv_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts hits, runs the coincidence gap test and classifies ids.
// Depends on cebv_pkg; feeds cebv_cmd_queue.
module cebv_front
    import cebv_pkg::*;
#(
    parameter int CHANNELS_PER_GROUP = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  t_hit        i_hit,
    output logic        o_stall,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [5:0] A_END = 6'(int'(GROUP_A_FIRST_ID) + CHANNELS_PER_GROUP);
    localparam logic [5:0] B_END = 6'(int'(GROUP_B_FIRST_ID) + CHANNELS_PER_GROUP);

    logic [15:0] r_window;
    logic [31:0] r_prev_time;
    logic        r_event_start;

    logic [31:0] gap;
    logic [5:0]  id_ext;
    logic        accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign o_push  = accept;
    assign id_ext  = {1'b0, i_hit.detector_id};

    always_comb begin
        gap = (i_hit.hit_time >= r_prev_time) ? (i_hit.hit_time - r_prev_time)
                                              : (r_prev_time - i_hit.hit_time);
        o_cmd            = '0;
        o_cmd.flush_pre  = !r_event_start && (gap > {16'd0, r_window});
        o_cmd.flush_post = i_hit.end_of_event;
        o_cmd.energy     = i_hit.hit_energy;
        if (id_ext >= {1'b0, GROUP_A_FIRST_ID} && id_ext < A_END) begin
            o_cmd.add_chan = 1'b1;
            o_cmd.chan     = CHAN_IDX_W'(i_hit.detector_id - GROUP_A_FIRST_ID);
        end else if (id_ext >= {1'b0, GROUP_B_FIRST_ID} && id_ext < B_END) begin
            o_cmd.add_chan = 1'b1;
            o_cmd.chan     = CHAN_IDX_W'(CHANNELS_PER_GROUP)
                           + CHAN_IDX_W'(i_hit.detector_id - GROUP_B_FIRST_ID);
        end else if (i_hit.detector_id == GUARD_ID) begin
            o_cmd.add_guard = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= WINDOW_AT_RESET;
            r_prev_time   <= '0;
            r_event_start <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (accept) begin
                r_prev_time   <= i_hit.hit_time;
                r_event_start <= i_hit.end_of_event;
            end
        end
    end

endmodule

// ----- hdl/cebv_cmd_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on cebv_pkg for the command type and depth.
module cebv_cmd_queue
    import cebv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_QUEUE_DEPTH - 1);

    t_cmd             r_mem [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(CMD_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/cebv_back.sv -----
`timescale 1ns / 1ps
// Back end: channel and guard sums, flush sequencing and the result register.
// Depends on cebv_pkg; takes commands from cebv_cmd_queue.
module cebv_back
    import cebv_pkg::*;
#(
    parameter int CHANNELS_PER_GROUP = 4,
    parameter int SUM_BITS           = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_stall
);

    localparam int NCH  = 2 * CHANNELS_PER_GROUP;
    localparam int CH_W = $clog2(NCH);
    localparam int EXT_W = SUM_BITS + ENERGY_OUT_W;

    function automatic logic [CH_W-1:0] lowest_set(input logic [NCH-1:0] v);
        logic [CH_W-1:0] idx;
        idx = '0;
        for (int k = NCH - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = CH_W'(k);
            end
        end
        return idx;
    endfunction

    t_bk_state             r_state;
    t_bk_state             n_state;
    t_cmd                  r_cmd;
    t_cmd                  n_cmd;
    logic [SUM_BITS-1:0]   r_sums [NCH];
    logic [NCH-1:0]        r_nz;
    logic [NCH-1:0]        n_nz;
    logic [SUM_BITS-1:0]   r_guard;
    logic [SUM_BITS-1:0]   n_guard;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic                  emit_pending;
    logic                  emit;
    logic                  slot_free;
    logic                  add_step;
    logic                  post_done;
    logic [CH_W-1:0]       low_idx;
    logic [CH_W-1:0]       add_idx;
    logic [CH_W-1:0]       rd_idx;
    logic [SUM_BITS-1:0]   rd_sum;
    logic [SUM_BITS:0]     chan_wide;
    logic [SUM_BITS-1:0]   chan_sat;
    logic [SUM_BITS-1:0]   guard_base;
    logic [SUM_BITS:0]     guard_wide;
    logic [EXT_W-1:0]      sum_ext;
    logic [NCH-1:0]        rest;

    assign slot_free    = !r_out_valid || !i_stall;
    assign emit_pending = ((r_state == BK_PRE && r_cmd.flush_pre) ||
                           (r_state == BK_POST && r_cmd.flush_post)) && (r_nz != '0);
    assign emit         = emit_pending && slot_free;
    assign add_step     = (r_state == BK_PRE) && !emit_pending;
    assign post_done    = (r_state == BK_POST) && !emit_pending;

    assign low_idx = lowest_set(r_nz);
    assign add_idx = r_cmd.chan[CH_W-1:0];
    assign rd_idx  = add_step ? add_idx : low_idx;
    assign rd_sum  = r_nz[rd_idx] ? r_sums[rd_idx] : '0;
    assign rest    = r_nz & ~(NCH'(1) << low_idx);

    // Saturating adds
    assign chan_wide  = {1'b0, rd_sum} + (SUM_BITS + 1)'(r_cmd.energy);
    assign chan_sat   = chan_wide[SUM_BITS] ? '1 : chan_wide[SUM_BITS-1:0];
    assign guard_base = r_cmd.flush_pre ? '0 : r_guard;
    assign guard_wide = {1'b0, guard_base} + (SUM_BITS + 1)'(r_cmd.energy);
    assign sum_ext    = EXT_W'(rd_sum);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = BK_PRE;
                end
            end
            BK_PRE: begin
                if (add_step) begin
                    n_state = BK_POST;
                end
            end
            BK_POST: begin
                if (post_done) begin
                    n_state = i_cmd_valid ? BK_PRE : BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_cmd_pop   = 1'b0;
        n_cmd       = r_cmd;
        n_nz        = r_nz;
        n_guard     = r_guard;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            BK_PRE: begin
                if (add_step) begin
                    n_guard = guard_base;
                    if (r_cmd.add_guard) begin
                        n_guard = guard_wide[SUM_BITS] ? '1 : guard_wide[SUM_BITS-1:0];
                    end
                    if (r_cmd.add_chan) begin
                        n_nz[add_idx] = (chan_sat != '0);
                    end
                end
            end
            BK_POST: begin
                if (post_done) begin
                    o_cmd_pop = i_cmd_valid;
                    if (r_cmd.flush_post) begin
                        n_guard = '0;
                    end
                end
            end
            default: begin
                n_nz = r_nz;
            end
        endcase
        if (o_cmd_pop) begin
            n_cmd = i_cmd;
        end
        if (emit) begin
            n_nz[low_idx]    = 1'b0;
            n_out_valid      = 1'b1;
            n_out.channel    = 3'(low_idx);
            n_out.energy_sum = (sum_ext > EXT_W'({ENERGY_OUT_W{1'b1}}))
                             ? '1 : sum_ext[ENERGY_OUT_W-1:0];
            n_out.vetoed     = (r_guard != '0);
            n_out.last       = (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
        if (add_step && r_cmd.add_chan) begin
            r_sums[add_idx] <= chan_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_nz        <= '0;
            r_guard     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nz        <= n_nz;
            r_guard     <= n_guard;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- hdl/coincidence_event_builder_veto_unit.sv -----
`timescale 1ns / 1ps
// Coincidence event builder with anticoincidence veto, top level.
// Depends on cebv_pkg, cebv_front, cebv_cmd_queue and cebv_back.
//
// Input channel: i_valid / o_stall with one t_hit beat per hit. Output
// channel: o_valid / i_stall with one t_result beat per nonzero channel of
// a flushed group; last marks the final beat of each flush. A beat moves at
// a rising edge with valid high and stall low.
// The front end takes a hit, tests the gap against time_window and queues
// a command; o_stall rises only while the two-entry command queue is full.
// The back end loads a command when idle, or straight after the previous
// one; it then emits one result beat per nonzero channel for a pre-hit
// (gap) flush, adds the energy, and emits the end-of-event flush beats the
// same way before it takes the next command. When i_stall is high a valid
// result beat holds and the back end waits before emitting another; the
// queue keeps taking hits until full.
// Reset (synchronous, active low) sets time_window to 300, clears all sums,
// empties the queue and restarts event tracking. The window register is
// written from i_cfg_wr_data at any edge with i_cfg_wr_en high, out of reset.
module coincidence_event_builder_veto_unit
    import cebv_pkg::*;
#(
    parameter int CHANNELS_PER_GROUP = 4,
    parameter int SUM_BITS           = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  t_hit        i_hit,
    output logic        o_stall,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_stall
);

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic cmd_valid;
    t_cmd head_cmd;

    cebv_front #(
        .CHANNELS_PER_GROUP(CHANNELS_PER_GROUP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .i_hit        (i_hit),
        .o_stall      (o_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    cebv_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_cmd),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_valid(cmd_valid),
        .o_data (head_cmd)
    );

    cebv_back #(
        .CHANNELS_PER_GROUP(CHANNELS_PER_GROUP),
        .SUM_BITS          (SUM_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (head_cmd),
        .o_cmd_pop  (pop),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_stall    (i_stall)
    );

endmodule

// ----- dv/coincidence_event_builder_veto_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the coincidence event builder with veto.
// Depends on cebv_pkg and coincidence_event_builder_veto_unit; predicts result
// beats per hit and compares them in order against the output channel.
module coincidence_event_builder_veto_unit_tb;
    import cebv_pkg::*;

    localparam int GROUP_SIZE = 4;
    localparam int SUM_W      = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam int SETTLE     = 24;          // cycles for hits that emit nothing
    localparam int HOLD_LONG  = 300;
    localparam int PHASE_HITS = 57;
    localparam int PHASES     = 6;
    localparam int ROWS       = 19;

    // Directed row; sum/veto are the single expected beat where known is set
    typedef struct packed {
        logic [31:0] at_ns;
        logic [4:0]  id;
        logic [15:0] energy;
        logic        eoe;
        logic        known;
        logic [2:0]  ch;
        logic [19:0] sum;
        logic        veto;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    t_hit        i_hit = '0;
    logic        o_stall;
    logic        o_valid;
    t_result     o_result;
    logic        i_stall = 1'b0;

    coincidence_event_builder_veto_unit #(
        .CHANNELS_PER_GROUP(GROUP_SIZE),
        .SUM_BITS(SUM_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid),
        .i_hit(i_hit),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_result(o_result),
        .i_stall(i_stall)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    logic [SUM_W-1:0] chan_sum [2*GROUP_SIZE];
    logic [SUM_W-1:0] guard_acc;
    logic [31:0]      last_hit_ns;
    bit               event_open;
    logic [15:0]      window_ns;

    t_result beats_due [$];
    t_result step_beats [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_hits = 0;

    t_row plan [ROWS] = '{
        // extremes: id 1, full energy; then time zero on the top channel
        '{32'd100,        5'd1,  16'hFFFF, 1'b1, 1'b1, 3'd0, 20'h0FFFF, 1'b0},
        '{32'd0,          5'd12, 16'h0001, 1'b1, 1'b1, 3'd7, 20'h00001, 1'b0},
        // guard hit vetoes the group
        '{32'd50,         5'd20, 16'h0005, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd60,         5'd9,  16'h0007, 1'b1, 1'b1, 3'd4, 20'h00007, 1'b1},
        // guard alone flushes nothing; other ids add nothing
        '{32'd70,         5'd20, 16'h0009, 1'b1, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd80,         5'd31, 16'hFFFF, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd90,         5'd0,  16'h1234, 1'b1, 1'b0, 3'd0, 20'h0,     1'b0},
        // gap equal to the window keeps the group together
        '{32'd1000,       5'd2,  16'h0003, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd1300,       5'd2,  16'h0004, 1'b1, 1'b1, 3'd1, 20'h00007, 1'b0},
        // gap one past the window: gap flush, then end-of-event flush
        '{32'd2000,       5'd3,  16'h000A, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd2301,       5'd4,  16'h000B, 1'b1, 1'b0, 3'd0, 20'h0,     1'b0},
        // backward time, gap measured as absolute difference
        '{32'd5000,       5'd10, 16'h0001, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd4699,       5'd11, 16'h0002, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd4699,       5'd11, 16'h0003, 1'b1, 1'b1, 3'd6, 20'h00005, 1'b0},
        // top of time range with zero energy, then a huge gap over empty sums
        '{32'hFFFF_FFFF,  5'd4,  16'h0000, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd0,          5'd1,  16'h0001, 1'b1, 1'b1, 3'd0, 20'h00001, 1'b0},
        '{32'd0,          5'd20, 16'hFFFF, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd0,          5'd1,  16'h0002, 1'b0, 1'b0, 3'd0, 20'h0,     1'b0},
        '{32'd1,          5'd12, 16'h0003, 1'b1, 1'b0, 3'd0, 20'h0,     1'b0}
    };

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] acc,
                                                     input logic [15:0] e);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + SUM_W'(e);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    task automatic clear_group();
        foreach (chan_sum[c]) chan_sum[c] = '0;
        guard_acc = '0;
    endtask

    // Emit one beat per nonzero channel, last on the highest one, then clear
    task automatic emit_group();
        int      final_ch;
        t_result b;
        final_ch = -1;
        foreach (chan_sum[c]) if (chan_sum[c] != 0) final_ch = c;
        foreach (chan_sum[c]) begin
            if (chan_sum[c] != 0) begin
                b.channel    = 3'(c);
                b.energy_sum = ENERGY_OUT_W'(chan_sum[c]);
                b.vetoed     = (guard_acc != 0);
                b.last       = (c == final_ch);
                step_beats.push_back(b);
            end
        end
        clear_group();
    endtask

    task automatic absorb_hit(input t_hit h);
        logic [31:0] gap;
        step_beats.delete();
        gap = (h.hit_time >= last_hit_ns) ? h.hit_time - last_hit_ns
                                          : last_hit_ns - h.hit_time;
        if (event_open && gap > {16'd0, window_ns}) emit_group();
        if (h.detector_id >= GROUP_A_FIRST_ID &&
            h.detector_id < GROUP_A_FIRST_ID + GROUP_SIZE) begin
            chan_sum[h.detector_id - GROUP_A_FIRST_ID] =
                add_clamped(chan_sum[h.detector_id - GROUP_A_FIRST_ID], h.hit_energy);
        end else if (h.detector_id >= GROUP_B_FIRST_ID &&
                     h.detector_id < GROUP_B_FIRST_ID + GROUP_SIZE) begin
            chan_sum[GROUP_SIZE + h.detector_id - GROUP_B_FIRST_ID] =
                add_clamped(chan_sum[GROUP_SIZE + h.detector_id - GROUP_B_FIRST_ID],
                            h.hit_energy);
        end else if (h.detector_id == GUARD_ID) begin
            guard_acc = add_clamped(guard_acc, h.hit_energy);
        end
        last_hit_ns = h.hit_time;
        event_open  = 1'b1;
        if (h.end_of_event) begin
            emit_group();
            event_open = 1'b0;
        end
    endtask

    // Offer one hit, hold it until taken, then log its beats
    task automatic send_hit(input t_hit h, input bit known, input t_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_hit   <= h;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_hit(h);
        if (known) beats_due.push_back(want);
        else foreach (step_beats[k]) beats_due.push_back(step_beats[k]);
        sent_hits++;
    endtask

    task automatic drain();
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] w);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_ns = w;
    endtask

    function automatic logic [4:0] pick_live_id();
        int r;
        r = $urandom_range(0, 2 * GROUP_SIZE);
        if (r < GROUP_SIZE) return GROUP_A_FIRST_ID + 5'(r);
        if (r < 2 * GROUP_SIZE) return GROUP_B_FIRST_ID + 5'(r - GROUP_SIZE);
        return GUARD_ID;
    endfunction

    function automatic logic [15:0] pick_energy();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // One event: mostly well-formed, some pile-ups that clamp, some noise
    task automatic random_event();
        t_hit        h;
        t_result     none;
        int          kind;
        int          n;
        int          r;
        bit          drop_eoe;
        logic [31:0] stride;
        none = '0;
        kind = $urandom_range(99);
        if (kind < 8) begin
            h.hit_time     = $urandom;
            h.detector_id  = 5'($urandom);
            h.hit_energy   = 16'($urandom);
            h.end_of_event = 1'($urandom);
            send_hit(h, 1'b0, none);
        end else if (kind < 13) begin
            n = $urandom_range(17, 20);
            h.hit_time    = $urandom;
            h.detector_id = pick_live_id();
            for (int k = 0; k < n; k++) begin
                h.hit_energy   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF;
                h.end_of_event = (k == n - 1);
                send_hit(h, 1'b0, none);
            end
        end else begin
            n        = $urandom_range(1, 9);
            drop_eoe = ($urandom_range(9) == 0);
            h.hit_time = $urandom;
            for (int k = 0; k < n; k++) begin
                if (k != 0) begin
                    r = $urandom_range(99);
                    if (r < 70) stride = $urandom_range(0, window_ns);
                    else if (r < 90) stride = window_ns + 32'd1 + $urandom_range(0, 999);
                    else stride = $urandom;
                    if ($urandom_range(4) == 0) h.hit_time = h.hit_time - stride;
                    else h.hit_time = h.hit_time + stride;
                end
                h.detector_id  = ($urandom_range(9) == 0) ? 5'($urandom) : pick_live_id();
                h.hit_energy   = pick_energy();
                h.end_of_event = (k == n - 1) && !drop_eoe;
                send_hit(h, 1'b0, none);
            end
        end
    endtask

    // Receiver: random stall, plus a long hold when asked
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LONG;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each taken beat with the oldest prediction
    always @(posedge i_clk) begin : beat_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat ch %0d sum %h",
                                          o_result.channel, o_result.energy_sum));
            end else begin
                want = beats_due.pop_front();
                if (o_result.channel !== want.channel)
                    report_mismatch($sformatf("channel %0d, want %0d",
                                              o_result.channel, want.channel));
                if (o_result.energy_sum !== want.energy_sum)
                    report_mismatch($sformatf("ch %0d energy_sum %h, want %h",
                                              want.channel, o_result.energy_sum,
                                              want.energy_sum));
                if (o_result.vetoed !== want.vetoed)
                    report_mismatch($sformatf("ch %0d vetoed %b, want %b",
                                              want.channel, o_result.vetoed, want.vetoed));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("ch %0d last %b, want %b",
                                              want.channel, o_result.last, want.last));
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_hit        h;
        t_result     want;
        logic [15:0] windows [PHASES];
        windows = '{16'd0, 16'hFFFF, 16'd300, 16'($urandom_range(2, 2000)), 16'd1,
                    16'($urandom_range(2, 2000))};
        clear_group();
        last_hit_ns = '0;
        event_open  = 1'b0;
        window_ns   = WINDOW_AT_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct = 67;
        foreach (plan[k]) begin
            h    = '{hit_time: plan[k].at_ns, detector_id: plan[k].id,
                     hit_energy: plan[k].energy, end_of_event: plan[k].eoe};
            want = '{channel: plan[k].ch, energy_sum: plan[k].sum,
                     vetoed: plan[k].veto, last: 1'b1};
            send_hit(h, plan[k].known, want);
        end
        i_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_window(windows[p]);
            send_idle_pct = (p < 2) ? 10 : (p < 4) ? 67 : 0;
            recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 10 : 0;
            // hold the output long enough that the command queue fills up
            if (p == 0) hold_asks++;
            sent_hits = 0;
            while (sent_hits < PHASE_HITS) random_event();
            i_valid <= 1'b0;
        end

        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
